[hdl/ple_pkg.sv]
// shared types and constants for the positional list engine
`default_nettype none
package ple_pkg;

  localparam int DEPTH   = 64;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int POS_W   = 7;
  localparam int WORD_W  = 32;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_NONE   = 2'd3
  } ple_func_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_RSVD   = 2'd3
  } ple_status_t;

  typedef struct packed {
    logic [1:0]               func;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] value;
  } ple_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] word_out;
    logic [POS_W-1:0]         entry_count;
  } ple_out_t;

  typedef struct packed {
    logic              ins;
    logic              del;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] value;
  } ple_ctl_t;

endpackage
`default_nettype wire

[hdl/positional_list_engine.sv]
// top level of the positional list engine: command decode, cell row, result register
// usage
//   in_valid/in_ready/in_data carry one command: insert, delete or read at a
//   1-based position. out_valid/out_ready/out_data carry one result for each
//   command: status, word removed or read, and entry count afterwards.
//   a command's result appears in the result register in the cycle after
//   acceptance. one command per cycle is sustained while results are taken,
//   since all cells at or past the position shift toward or away from the
//   tail in the same cycle and the read is a select over the cell row.
//   when the receiver stalls, the result register holds its transaction and
//   in_ready stays low until it is taken; a new command is accepted in the
//   cycle the held result leaves.
//   reset (rst_n low, synchronous) empties the list and drops any pending
//   result; cell contents are not cleared and are never read before written.
//   insert accepts positions 1 to count+1, delete and read 1 to count;
//   anything else reports bad position, an insert into a full list reports
//   full, and the list is unchanged in both cases.
`default_nettype none
module positional_list_engine (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire ple_pkg::ple_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output ple_pkg::ple_out_t     out_data
);
  import ple_pkg::*;

  logic              accept;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              out_valid_r;
  ple_out_t          out_r;
  ple_out_t          out_nxt;
  ple_ctl_t          ctl;
  logic [CNT_W:0]    pos_ext;
  logic              ins_pos_ok;
  logic              acc_pos_ok;
  logic              full;
  logic [WORD_W-1:0] read_word;

  logic [WORD_W-1:0] cell_word [DEPTH];
  logic [WORD_W-1:0] cell_tap  [DEPTH];

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign pos_ext    = (CNT_W + 1)'(in_data.position);
  assign ins_pos_ok = (pos_ext != '0) && (pos_ext <= ({1'b0, count_r} + 1'b1));
  assign acc_pos_ok = (pos_ext != '0) && (pos_ext <= {1'b0, count_r});
  assign full       = (count_r == CNT_W'(DEPTH));

  always_comb begin
    read_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      read_word = read_word | cell_tap[i];
    end
  end

  always_comb begin
    ctl.ins   = 1'b0;
    ctl.del   = 1'b0;
    ctl.idx   = IDX_W'(in_data.position - 1'b1);
    ctl.value = in_data.value;
    count_nxt = count_r;
    out_nxt.status   = ST_BADPOS;
    out_nxt.word_out = '0;
    unique case (ple_func_t'(in_data.func))
      FUNC_INSERT: begin
        if (ins_pos_ok) begin
          if (full) begin
            out_nxt.status = ST_FULL;
          end else begin
            ctl.ins        = accept;
            count_nxt      = count_r + 1'b1;
            out_nxt.status = ST_OK;
          end
        end
      end
      FUNC_DELETE: begin
        if (acc_pos_ok) begin
          ctl.del          = accept;
          count_nxt        = count_r - 1'b1;
          out_nxt.status   = ST_OK;
          out_nxt.word_out = read_word;
        end
      end
      FUNC_READ: begin
        if (acc_pos_ok) begin
          out_nxt.status   = ST_OK;
          out_nxt.word_out = read_word;
        end
      end
      default: begin
        out_nxt.status = ST_BADPOS;
      end
    endcase
    out_nxt.entry_count = POS_W'(count_nxt);
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_W-1:0] left_w;
    logic [WORD_W-1:0] right_w;
    if (g == 0) begin : g_head
      assign left_w = in_data.value;
    end else begin : g_mid_l
      assign left_w = cell_word[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right_w = cell_word[g];
    end else begin : g_mid_r
      assign right_w = cell_word[g+1];
    end
    ple_cell u_cell (
      .clk        (clk),
      .cell_idx   (IDX_W'(g)),
      .ctl        (ctl),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (cell_word[g]),
      .tap        (cell_tap[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

[hdl/ple_cell.sv]
// one storage cell of the shifting entry row
`default_nettype none
module ple_cell (
  input  wire logic                      clk,
  input  wire logic [ple_pkg::IDX_W-1:0]  cell_idx,
  input  wire ple_pkg::ple_ctl_t         ctl,
  input  wire logic [ple_pkg::WORD_W-1:0] left_word,
  input  wire logic [ple_pkg::WORD_W-1:0] right_word,
  output logic      [ple_pkg::WORD_W-1:0] word,
  output logic      [ple_pkg::WORD_W-1:0] tap
);
  import ple_pkg::*;

  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] word_nxt;
  logic              at_pos;
  logic              past_pos;

  assign at_pos   = (cell_idx == ctl.idx);
  assign past_pos = (cell_idx > ctl.idx);

  always_comb begin
    word_nxt = word_r;
    if (ctl.ins) begin
      if (at_pos) begin
        word_nxt = ctl.value;
      end else if (past_pos) begin
        word_nxt = left_word;
      end
    end else if (ctl.del) begin
      if (at_pos || past_pos) begin
        word_nxt = right_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;
  assign tap  = at_pos ? word_r : '0;

endmodule
`default_nettype wire

[hdl/ple_checker.sv]
// port level checks for the positional list engine, bound to the top level
`default_nettype none
module ple_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire ple_pkg::ple_in_t  in_data,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire ple_pkg::ple_out_t out_data
);
  import ple_pkg::*;

  // held result stays put while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.entry_count <= POS_W'(DEPTH))
    else $error("entry count above depth");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.word_out == '0)
    else $error("failed command returned a word");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FULL |-> out_data.entry_count == POS_W'(DEPTH))
    else $error("full status with room left");

  // an insert transaction with a good result grows the count by one
  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.func == FUNC_INSERT && out_valid && out_ready
    |=> out_data.status != ST_OK
        || out_data.entry_count == $past(out_data.entry_count) + 1'b1)
    else $error("insert did not grow the count");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

[bench/positional_list_engine_tb.sv]
// testbench for the positional list engine: bursty commands, stalling receiver, scoreboard check
`default_nettype none
module positional_list_engine_tb;
  import ple_pkg::*;

  localparam int NUM_RANDOM = 1000;
  localparam int IDLE_LIMIT = 2000;

  class list_scoreboard;
    logic signed [WORD_W-1:0] cells [DEPTH];
    int count = 0;
    int errors = 0;
    ple_out_t expected_q [$];

    function void note_command(ple_in_t c);
      ple_out_t e;
      int p;
      p = int'(c.position);
      e.status = ST_BADPOS;
      e.word_out = '0;
      case (c.func)
        FUNC_INSERT: begin
          if (p >= 1 && p <= count + 1) begin
            if (count >= DEPTH) begin
              e.status = ST_FULL;
            end else begin
              for (int i = count; i > p - 1; i--) cells[i] = cells[i-1];
              cells[p-1] = c.value;
              count++;
              e.status = ST_OK;
            end
          end
        end
        FUNC_DELETE: begin
          if (p >= 1 && p <= count) begin
            e.word_out = cells[p-1];
            for (int i = p - 1; i < count - 1; i++) cells[i] = cells[i+1];
            count--;
            e.status = ST_OK;
          end
        end
        FUNC_READ: begin
          if (p >= 1 && p <= count) begin
            e.word_out = cells[p-1];
            e.status = ST_OK;
          end
        end
        default: ;
      endcase
      e.entry_count = count[POS_W-1:0];
      expected_q.push_back(e);
    endfunction

    function void check_result(ple_out_t r);
      ple_out_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result status %0d word %0d count %0d",
                 $time, r.status, r.word_out, r.entry_count);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (r.status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, r.status);
        errors++;
      end
      if (r.word_out !== e.word_out) begin
        $display("%0t: word_out expected %0d actual %0d", $time, e.word_out, r.word_out);
        errors++;
      end
      if (r.entry_count !== e.entry_count) begin
        $display("%0t: entry_count expected %0d actual %0d",
                 $time, e.entry_count, r.entry_count);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  ple_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ple_out_t out_data;

  list_scoreboard book;
  int burst_left = 0;
  int stall_mode = 0;
  int mode_cycles = 0;
  int stall_phase = 0;
  int idle_cycles = 0;

  positional_list_engine i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic ple_in_t make_cmd(ple_func_t f, int p, logic [WORD_W-1:0] v);
    ple_in_t c;
    c.func = f;
    c.position = p[POS_W-1:0];
    c.value = v;
    return c;
  endfunction

  function automatic ple_in_t pick_command(int occ, int fill_bias);
    ple_in_t c;
    int k;
    int hi;
    k = $urandom_range(0, 99);
    if (k < fill_bias) c.func = FUNC_INSERT;
    else if (k < 95) c.func = ($urandom_range(0, 1) != 0) ? FUNC_DELETE : FUNC_READ;
    else c.func = FUNC_NONE;
    hi = (c.func == FUNC_INSERT) ? occ + 1 : occ;
    k = $urandom_range(0, 99);
    if (hi == 0 || k < 10) c.position = POS_W'($urandom_range(0, 127));
    else if (k < 30) c.position = POS_W'(1);
    else if (k < 50) c.position = hi[POS_W-1:0];
    else c.position = POS_W'($urandom_range(1, hi));
    c.value = $urandom;
    return c;
  endfunction

  task automatic issue(ple_in_t c);
    int gap;
    in_valid <= 1'b1;
    in_data <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.note_command(c);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // result check and receiver stall pattern
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) book.check_result(out_data);
    if (mode_cycles == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_cycles <= $urandom_range(20, 120);
    end else begin
      mode_cycles <= mode_cycles - 1;
    end
    stall_phase <= (stall_phase == 4) ? 0 : stall_phase + 1;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (stall_phase == 0);
      default: out_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int fill_bias;
    book = new;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty list, range checks, extreme values, every operation
    issue(make_cmd(FUNC_READ, 1, 32'h0000_0000));
    issue(make_cmd(FUNC_DELETE, 1, 32'h0000_0000));
    issue(make_cmd(FUNC_INSERT, 0, 32'h1234_5678));
    issue(make_cmd(FUNC_INSERT, 2, 32'h1234_5678));
    issue(make_cmd(FUNC_INSERT, 1, 32'h7fff_ffff));
    issue(make_cmd(FUNC_INSERT, 1, 32'h8000_0000));
    issue(make_cmd(FUNC_INSERT, 3, 32'h0000_0000));
    issue(make_cmd(FUNC_INSERT, 2, 32'hffff_ffff));
    issue(make_cmd(FUNC_READ, 1, 32'h0000_0000));
    issue(make_cmd(FUNC_READ, 4, 32'h0000_0000));
    issue(make_cmd(FUNC_READ, 5, 32'h0000_0000));
    issue(make_cmd(FUNC_READ, 0, 32'h0000_0000));
    issue(make_cmd(FUNC_DELETE, 127, 32'h0000_0000));
    issue(make_cmd(FUNC_NONE, 1, 32'hffff_ffff));
    issue(make_cmd(FUNC_INSERT, 127, 32'h5555_aaaa));
    issue(make_cmd(FUNC_DELETE, 4, 32'h0000_0000));
    issue(make_cmd(FUNC_DELETE, 1, 32'h0000_0000));
    issue(make_cmd(FUNC_DELETE, 2, 32'h0000_0000));
    issue(make_cmd(FUNC_READ, 1, 32'h0000_0000));
    issue(make_cmd(FUNC_DELETE, 1, 32'h0000_0000));
    issue(make_cmd(FUNC_READ, 1, 32'h0000_0000));

    // phases that lean toward filling, draining or churning the list
    fill_bias = 50;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 150 == 0) begin
        case ($urandom_range(0, 2))
          0: fill_bias = 80;
          1: fill_bias = 20;
          default: fill_bias = 50;
        endcase
      end
      issue(pick_command(book.count, fill_bias));
    end
    in_valid <= 1'b0;

    while (book.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (book.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

[sim.f]
hdl/ple_pkg.sv
hdl/ple_cell.sv
hdl/positional_list_engine.sv
hdl/ple_checker.sv
bench/positional_list_engine_tb.sv
